// File: design/bdta_pkg.sv
package bdta_pkg;

    localparam int OBJECTS    = 1024;
    localparam int ADDR_W     = $clog2(OBJECTS);
    localparam int IDX_W      = 10;
    localparam int COORD_W    = 24;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int THR_W      = 24;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int TIER_W     = 3;
    localparam int BUDGET_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 160;
    localparam int M_TDATA_W  = 16;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);

    localparam logic [TIER_W-1:0] TIER_HERO  = 3'd0;
    localparam logic [TIER_W-1:0] TIER_NEAR  = 3'd1;
    localparam logic [TIER_W-1:0] TIER_MID   = 3'd2;
    localparam logic [TIER_W-1:0] TIER_FAR   = 3'd3;
    localparam logic [TIER_W-1:0] TIER_CHEAP = 3'd4;
    localparam logic [TIER_W-1:0] TIER_RESET = TIER_FAR;

    localparam logic [THR_W-1:0]    HERO_RST   = 24'd2048;
    localparam logic [THR_W-1:0]    NEAR_RST   = 24'd6400;
    localparam logic [THR_W-1:0]    MID_RST    = 24'd15360;
    localparam logic [THR_W-1:0]    FAR_RST    = 24'd30720;
    localparam logic [BUDGET_W-1:0] BUDGET_RST = 16'd4;

    localparam logic [SQ_W-1:0] HERO_SQ_RST = SQ_W'(HERO_RST) * SQ_W'(HERO_RST);
    localparam logic [SQ_W-1:0] NEAR_SQ_RST = SQ_W'(NEAR_RST) * SQ_W'(NEAR_RST);
    localparam logic [SQ_W-1:0] MID_SQ_RST  = SQ_W'(MID_RST) * SQ_W'(MID_RST);
    localparam logic [SQ_W-1:0] FAR_SQ_RST  = SQ_W'(FAR_RST) * SQ_W'(FAR_RST);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HERO   = 3'd0,
        CFG_NEAR   = 3'd1,
        CFG_MID    = 3'd2,
        CFG_FAR    = 3'd3,
        CFG_BUDGET = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [TIER_W-1:0] want;
        logic              last;
    } q_item_t;

endpackage

// File: design/bdta_ram.sv
module bdta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/bdta_front.sv
module bdta_front
    import bdta_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic [S_TDATA_W-1:0]  in_data,
    input  logic                  in_last,
    input  logic                  hold,
    output logic                  in_ready,
    input  logic                  q_full,
    output logic                  q_push,
    output q_item_t               q_item,
    output logic [BUDGET_W-1:0]   budget
);

    logic [SQ_W-1:0]     thr_sq_reg [4];
    logic [BUDGET_W-1:0] budget_reg;

    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IDX_W-1:0]    idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic                last1_reg, last2_reg, last3_reg, last4_reg;
    logic [COORD_W-1:0]  ad_reg [3];
    logic [COORD_W-1:0]  ad_next [3];
    logic [SQ_W-1:0]     sq_reg [3];
    logic [SUM_W-1:0]    sum_reg;
    logic [TIER_W-1:0]   want_reg;
    logic [TIER_W-1:0]   want_next;
    logic [COORD_W-1:0]  obj_c [3];
    logic [COORD_W-1:0]  cam_c [3];
    logic [DIFF_W-1:0]   diff [3];
    logic [SQ_W-1:0]     cfg_sq;
    logic                en;
    logic                take;

    // thresholds are kept squared; one multiplier serves every threshold write
    assign cfg_sq = SQ_W'(cfg_data[THR_W-1:0]) * SQ_W'(cfg_data[THR_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_sq_reg[0] <= HERO_SQ_RST;
            thr_sq_reg[1] <= NEAR_SQ_RST;
            thr_sq_reg[2] <= MID_SQ_RST;
            thr_sq_reg[3] <= FAR_SQ_RST;
            budget_reg    <= BUDGET_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HERO:   thr_sq_reg[0] <= cfg_sq;
                CFG_NEAR:   thr_sq_reg[1] <= cfg_sq;
                CFG_MID:    thr_sq_reg[2] <= cfg_sq;
                CFG_FAR:    thr_sq_reg[3] <= cfg_sq;
                CFG_BUDGET: budget_reg    <= cfg_data[BUDGET_W-1:0];
                default:    ;
            endcase
        end
    end

    assign budget = budget_reg;

    // whole pipe stalls only when the last stage cannot drain
    assign en       = !v4_reg || !q_full;
    assign in_ready = en && !hold;
    assign take     = in_valid && in_ready;
    assign q_push   = v4_reg && !q_full;
    assign q_item   = '{idx: idx4_reg, want: want_reg, last: last4_reg};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            obj_c[i] = in_data[IDX_W + i*COORD_W +: COORD_W];
            cam_c[i] = in_data[IDX_W + (i+3)*COORD_W +: COORD_W];
            diff[i]  = DIFF_W'(signed'(obj_c[i])) - DIFF_W'(signed'(cam_c[i]));
            ad_next[i] = diff[i][DIFF_W-1] ? COORD_W'(-diff[i]) : diff[i][COORD_W-1:0];
        end
    end

    // strict compares in order; first hit wins
    always_comb
    begin
        if (sum_reg < SUM_W'(thr_sq_reg[0]))
            want_next = TIER_HERO;
        else if (sum_reg < SUM_W'(thr_sq_reg[1]))
            want_next = TIER_NEAR;
        else if (sum_reg < SUM_W'(thr_sq_reg[2]))
            want_next = TIER_MID;
        else if (sum_reg < SUM_W'(thr_sq_reg[3]))
            want_next = TIER_FAR;
        else
            want_next = TIER_CHEAP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx1_reg  <= in_data[IDX_W-1:0];
            last1_reg <= in_last;
            for (int i = 0; i < 3; i++)
            begin
                ad_reg[i] <= ad_next[i];
                sq_reg[i] <= SQ_W'(ad_reg[i]) * SQ_W'(ad_reg[i]);
            end
            idx2_reg  <= idx1_reg;
            last2_reg <= last1_reg;
            sum_reg   <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            idx3_reg  <= idx2_reg;
            last3_reg <= last2_reg;
            want_reg  <= want_next;
            idx4_reg  <= idx3_reg;
            last4_reg <= last3_reg;
        end
    end

endmodule

// File: design/bdta_fifo.sv
module bdta_fifo
    import bdta_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    input  logic    pop,
    output q_item_t head,
    output logic    full,
    output logic    empty
);

    q_item_t           buf_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full  = count_reg == (QPTR_W+1)'(QDEPTH);
    assign empty = count_reg == '0;
    assign head  = buf_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// File: design/bdta_back.sv
module bdta_back
    import bdta_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [BUDGET_W-1:0]   budget,
    input  logic                  q_empty,
    input  q_item_t               q_head,
    output logic                  q_pop,
    output logic                  clearing,
    output logic                  ram_wr_en,
    output logic [ADDR_W-1:0]     ram_wr_addr,
    output logic [TIER_W-1:0]     ram_wr_data,
    output logic                  ram_rd_en,
    output logic [ADDR_W-1:0]     ram_rd_addr,
    input  logic [TIER_W-1:0]     ram_rd_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [M_TDATA_W-1:0]  m_data
);

    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_DECIDE = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg;
    logic [BUDGET_W-1:0]  count_reg, count_next;
    q_item_t              item_reg;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic                 slot_free;
    logic                 fire;
    logic                 in_range;
    logic [TIER_W-1:0]    cur;
    logic [TIER_W-1:0]    now;
    logic                 changed;
    logic                 held;
    logic                 do_write;

    assign clearing  = state_reg == ST_CLEAR;
    assign slot_free = !m_valid_reg || m_ready;
    assign fire      = (state_reg == ST_DECIDE) && slot_free;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign ram_rd_en   = q_pop;
    assign ram_rd_addr = ADDR_W'(q_head.idx);
    assign in_range    = 32'(item_reg.idx) < OBJECTS;
    assign cur         = ram_rd_data;

    always_comb
    begin
        now        = item_reg.want;
        changed    = 1'b0;
        held       = 1'b0;
        do_write   = 1'b0;
        count_next = count_reg;
        if (in_range)
        begin
            now = cur;
            if (item_reg.want < cur)
            begin
                if (count_reg < budget)
                begin
                    now        = item_reg.want;
                    changed    = 1'b1;
                    do_write   = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    held = 1'b1;
                end
            end
            else if (item_reg.want > cur)
            begin
                now      = item_reg.want;
                changed  = 1'b1;
                do_write = 1'b1;
            end
        end
        // judge under the current count, then clear at end of pass
        if (item_reg.last)
            count_next = '0;
    end

    always_comb
    begin
        if (clearing)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_reg;
            ram_wr_data = TIER_RESET;
        end
        else
        begin
            ram_wr_en   = fire && do_write;
            ram_wr_addr = ADDR_W'(item_reg.idx);
            ram_wr_data = item_reg.want;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
                if (clr_cnt_reg == ADDR_W'(OBJECTS - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (!q_empty)
                    state_next = ST_DECIDE;
            ST_DECIDE:
                if (slot_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (fire)
            begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_head;
        if (fire)
            m_data_reg <= {1'b0, held, changed, now, item_reg.idx};
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: design/budgeted_distance_tier_assign.sv
// Distance-based detail tier assignment with a per-pass promotion budget.
//
// Input stream (s_axis_*): one object per transaction, tlast marks the last
// object of a pass. Output stream (m_axis_*): one result per object, in order.
// Config channel (cfg_*): register index and data, always ready; write only
// while no object is in flight.
//
// Datapath: four front stages (abs difference, square, sum, threshold compare),
// the queue, then a tier store read and a decide/write-back step in the back end.
// Flow: the back end reads then writes the tier store for each object and takes
// a new object from the queue only after the last one is decided; the front end
// takes one per cycle until its queue fills.
//
// Reset: the tier store is swept to tier 3, one entry per cycle, over all 1024
// entries; s_axis_tready stays low during the sweep. Config registers return
// to their defaults and the promotion counter clears.
// Receiver stall: the result waits in the output register, the back end
// holds, the queue fills and s_axis_tready then drops.
module budgeted_distance_tier_assign
    import bdta_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // object_index[9:0], obj_x, obj_y, obj_z, cam_x, cam_y, cam_z (24 each), zero pad
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_index[9:0], tier_now[12:10], tier_changed[13], promotion_held[14], zero
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    logic                q_push, q_pop, q_full, q_empty;
    q_item_t             q_in, q_head;
    logic [BUDGET_W-1:0] budget;
    logic                clearing;
    logic                ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]   ram_wr_addr, ram_rd_addr;
    logic [TIER_W-1:0]   ram_wr_data, ram_rd_data;

    assign cfg_ready = 1'b1;

    bdta_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .hold      (clearing),
        .in_ready  (s_axis_tready),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_in),
        .budget    (budget)
    );

    bdta_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    bdta_ram #(
        .WIDTH (TIER_W),
        .DEPTH (OBJECTS)
    ) u_tier_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    bdta_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .budget      (budget),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .clearing    (clearing),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_data      (m_axis_tdata)
    );

endmodule
